[sv/wsts_pkg.sv]
// Package for the work-stealing task scheduler: state codes, command and
// status codes, register map constants and the result record.
// No dependencies.
package wsts_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RRMOD,
        S_POST,
        S_CHECK,
        S_SCAN,
        S_READ
    } t_state;

    localparam int CMD_W    = 1;
    localparam int WIDX_W   = 3;
    localparam int TASK_W   = 32;
    localparam int STATUS_W = 2;
    localparam int ACTIVE_W = 4;

    localparam logic [CMD_W-1:0] CMD_POST  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FETCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_WORKER = 2'd3;

    // APB map: one 32-bit register per word
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_WORKERS = 1'b0;
    localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET       = 4'd8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TASK_W-1:0]   handle;
        logic [WIDX_W-1:0]   worker;
        logic                stolen;
    } t_result;

endpackage

[sv/wsts_if.sv]
// Valid/ready channel interfaces for the scheduler's request and result sides.
// Depends on wsts_pkg for field widths.
interface wsts_req_if
    import wsts_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [WIDX_W-1:0] worker_index;
    logic [TASK_W-1:0] task_handle;

    modport source (output valid, command, worker_index, task_handle, input ready);
    modport sink   (input valid, command, worker_index, task_handle, output ready);
endinterface

interface wsts_rsp_if
    import wsts_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TASK_W-1:0]   task_handle_out;
    logic [WIDX_W-1:0]   queue_worker;
    logic                was_stolen;

    modport source (output valid, status, task_handle_out, queue_worker, was_stolen,
                    input ready);
    modport sink   (input valid, status, task_handle_out, queue_worker, was_stolen,
                    output ready);
endinterface

[sv/work_stealing_task_scheduler.sv]
// Work-stealing task scheduler: per-worker bounded deques in one task RAM.
// Steps: a post accepts, reduces the pointer (repeated while above a shrunk
//   worker count), then writes the RAM; an own fetch checks and reads the RAM;
//   a steal scans victim queues in turn; an empty fetch scans all other live ones.
// Throughput: one request at a time; the result register frees the next accept.
// Reset (sync, active low) empties all queues, zeroes the pointer, sets 8 workers.
module work_stealing_task_scheduler
    import wsts_pkg::*;
#(
    parameter int MAX_WORKERS = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wsts_req_if.sink              i_req,
    wsts_rsp_if.source            o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int WID_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int NW      = $clog2(MAX_WORKERS + 1);
    localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W   = $clog2(2 * QUEUE_DEPTH);
    localparam int UW      = (POS_W > NW) ? POS_W : NW;
    localparam int CMP_W   = (NW > ACTIVE_W) ? NW : ACTIVE_W;
    localparam int SLOTS   = MAX_WORKERS * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int STORE_W = (HANDLE_BITS < TASK_W) ? HANDLE_BITS : TASK_W;

    // Queue w owns slots w*QUEUE_DEPTH .. +QUEUE_DEPTH-1 as a ring
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [WID_W-1:0]  wk,
                                                    input logic [HEAD_W-1:0] off);
        slot_addr = ADDR_W'(wk) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(off);
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [ACTIVE_W-1:0]   r_active;
    logic [WID_W-1:0]      r_rr;
    logic [HEAD_W-1:0]     r_head  [MAX_WORKERS];
    logic [CNT_W-1:0]      r_count [MAX_WORKERS];
    logic [WIDX_W-1:0]     r_req_w;
    logic [STORE_W-1:0]    r_req_h;
    logic [WID_W-1:0]      r_tgt;     // post target, own queue or steal victim
    logic [NW-1:0]         r_off;     // steal scan offset
    logic                  r_stolen;
    logic [STORE_W-1:0]    r_rdata;
    t_result               r_out;
    logic                  r_out_valid;
    logic [STORE_W-1:0]    r_store [SLOTS];

    // ------------------------------------------------------------------
    // Common decode
    // ------------------------------------------------------------------
    logic [NW-1:0]     live;
    logic              accept;
    logic              out_free;
    logic [WID_W-1:0]  wi;
    logic              w_bad;
    logic              own_nz;
    logic [CNT_W-1:0]  tgt_cnt;
    logic [HEAD_W-1:0] tgt_head;
    logic              tgt_full;
    logic              scan_done;

    always_comb begin
        if (r_active == '0) begin
            live = NW'(1);
        end else if (CMP_W'(r_active) > CMP_W'(MAX_WORKERS)) begin
            live = NW'(MAX_WORKERS);
        end else begin
            live = NW'(r_active);
        end
    end

    assign accept    = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign wi        = WID_W'(r_req_w);
    assign w_bad     = CMP_W'(r_req_w) >= CMP_W'(live);
    assign own_nz    = r_count[wi] != '0;
    assign tgt_cnt   = r_count[r_tgt];
    assign tgt_head  = r_head[r_tgt];
    assign tgt_full  = tgt_cnt == CNT_W'(QUEUE_DEPTH);
    assign scan_done = r_off >= live;

    // ------------------------------------------------------------------
    // Shared compare/subtract unit: pointer reduction and ring wrap
    // ------------------------------------------------------------------
    logic [UW-1:0]     u_a, u_b;
    logic [UW:0]       u_diff;
    logic              u_ge;
    logic [HEAD_W-1:0] ring_off;

    always_comb begin
        unique case (r_state)
            S_RRMOD: begin
                u_a = UW'(r_rr);
                u_b = UW'(live);
            end
            S_POST: begin
                u_a = UW'(tgt_head) + UW'(tgt_cnt);
                u_b = UW'(QUEUE_DEPTH);
            end
            S_CHECK: begin
                // newest task sits at head + count - 1
                u_a = UW'(r_head[wi]) + UW'(r_count[wi]) - UW'(1);
                u_b = UW'(QUEUE_DEPTH);
            end
            default: begin
                u_a = '0;
                u_b = '0;
            end
        endcase
    end

    assign u_diff   = {1'b0, u_a} - {1'b0, u_b};
    assign u_ge     = !u_diff[UW];
    assign ring_off = u_ge ? HEAD_W'(u_diff[UW-1:0]) : HEAD_W'(u_a);

    // Wrapping worker increment: next post target, first victim, next victim
    logic [NW-1:0] inc_src, inc_sum, inc_val;

    assign inc_src = (r_state == S_CHECK) ? NW'(r_req_w) : NW'(r_tgt);
    assign inc_sum = inc_src + NW'(1);
    assign inc_val = (inc_sum == live) ? '0 : inc_sum;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_req.command == CMD_POST) ? S_RRMOD : S_CHECK;
                end
            end
            S_RRMOD: begin
                if (!u_ge) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                priority if (w_bad) begin
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (own_nz) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (scan_done) begin
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (tgt_cnt != '0) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath controls
    // ------------------------------------------------------------------
    logic              ld_out;
    t_result           n_out;
    logic              rr_en;
    logic [WID_W-1:0]  n_rr;
    logic              tgt_en;
    logic [WID_W-1:0]  n_tgt;
    logic              off_en;
    logic [NW-1:0]     n_off;
    logic              stolen_en;
    logic              n_stolen;
    logic              cnt_en;
    logic [WID_W-1:0]  cnt_idx;
    logic [CNT_W-1:0]  n_cnt;
    logic              head_en;
    logic [HEAD_W-1:0] n_head;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;

    always_comb begin
        ld_out    = 1'b0;
        n_out     = '0;
        rr_en     = 1'b0;
        n_rr      = r_rr;
        tgt_en    = 1'b0;
        n_tgt     = r_tgt;
        off_en    = 1'b0;
        n_off     = r_off;
        stolen_en = 1'b0;
        n_stolen  = 1'b0;
        cnt_en    = 1'b0;
        cnt_idx   = r_tgt;
        n_cnt     = tgt_cnt;
        head_en   = 1'b0;
        n_head    = tgt_head;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = slot_addr(r_tgt, tgt_head);

        unique case (r_state)
            S_IDLE: begin
            end
            S_RRMOD: begin
                // pointer left above a shrunk count: subtract until in range
                if (u_ge) begin
                    rr_en = 1'b1;
                    n_rr  = WID_W'(u_diff[UW-1:0]);
                end else begin
                    tgt_en = 1'b1;
                    n_tgt  = r_rr;
                end
            end
            S_POST: begin
                if (out_free) begin
                    ld_out        = 1'b1;
                    n_out.status  = tgt_full ? ST_FULL : ST_OK;
                    n_out.worker  = WIDX_W'(r_tgt);
                    rr_en         = 1'b1;
                    n_rr          = WID_W'(inc_val);
                    if (!tgt_full) begin
                        mem_we   = 1'b1;
                        mem_addr = slot_addr(r_tgt, ring_off);
                        cnt_en   = 1'b1;
                        n_cnt    = tgt_cnt + CNT_W'(1);
                    end
                end
            end
            S_CHECK: begin
                priority if (w_bad) begin
                    if (out_free) begin
                        ld_out       = 1'b1;
                        n_out.status = ST_BAD_WORKER;
                    end
                end else if (own_nz) begin
                    // pop newest from own back
                    mem_re    = 1'b1;
                    mem_addr  = slot_addr(wi, ring_off);
                    cnt_en    = 1'b1;
                    cnt_idx   = wi;
                    n_cnt     = r_count[wi] - CNT_W'(1);
                    tgt_en    = 1'b1;
                    n_tgt     = wi;
                    stolen_en = 1'b1;
                    n_stolen  = 1'b0;
                end else begin
                    tgt_en = 1'b1;
                    n_tgt  = WID_W'(inc_val);
                    off_en = 1'b1;
                    n_off  = NW'(1);
                end
            end
            S_SCAN: begin
                priority if (scan_done) begin
                    if (out_free) begin
                        ld_out       = 1'b1;
                        n_out.status = ST_EMPTY;
                    end
                end else if (tgt_cnt != '0) begin
                    // steal oldest from victim front
                    mem_re    = 1'b1;
                    head_en   = 1'b1;
                    n_head    = (tgt_head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : tgt_head + HEAD_W'(1);
                    cnt_en    = 1'b1;
                    n_cnt     = tgt_cnt - CNT_W'(1);
                    stolen_en = 1'b1;
                    n_stolen  = 1'b1;
                end else begin
                    tgt_en = 1'b1;
                    n_tgt  = WID_W'(inc_val);
                    off_en = 1'b1;
                    n_off  = r_off + NW'(1);
                end
            end
            S_READ: begin
                if (out_free) begin
                    ld_out       = 1'b1;
                    n_out.status = ST_OK;
                    n_out.handle = TASK_W'(r_rdata);
                    n_out.worker = WIDX_W'(r_tgt);
                    n_out.stolen = r_stolen;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic cfg_we;

    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1:2] == REG_ACTIVE_WORKERS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= ACTIVE_RESET;
            r_rr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_we) begin
                r_active <= pwdata[ACTIVE_W-1:0];
            end
            if (rr_en) begin
                r_rr <= n_rr;
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_WORKERS; i++) begin
            if (!i_rst_n) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end else begin
                if (head_en && (r_tgt == WID_W'(i))) begin
                    r_head[i] <= n_head;
                end
                if (cnt_en && (cnt_idx == WID_W'(i))) begin
                    r_count[i] <= n_cnt;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_w <= i_req.worker_index;
            r_req_h <= STORE_W'(i_req.task_handle);
        end
        if (tgt_en) begin
            r_tgt <= n_tgt;
        end
        if (off_en) begin
            r_off <= n_off;
        end
        if (stolen_en) begin
            r_stolen <= n_stolen;
        end
        if (ld_out) begin
            r_out <= n_out;
        end
    end

    // Task RAM: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_addr] <= r_req_h;
        end
        if (mem_re) begin
            r_rdata <= r_store[mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.task_handle_out = r_out.handle;
    assign o_rsp.queue_worker    = r_out.worker;
    assign o_rsp.was_stolen      = r_out.stolen;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_ACTIVE_WORKERS)
                    ? {{(32 - ACTIVE_W){1'b0}}, r_active} : '0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_stolen_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.was_stolen) |-> (o_rsp.status == ST_OK))
        else $error("steal flagged on a failed request");

    a_err_no_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |-> (o_rsp.task_handle_out == '0))
        else $error("handle returned with error status");

    a_read_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ($past(r_state) == S_CHECK || $past(r_state) == S_SCAN
                                 || $past(r_state) == S_READ))
        else $error("result read without a RAM read issued");

endmodule
